// File: rtl/cbc_pkg.sv
// Shared types, constants and helper functions for the circle/box collision core.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package cbc_pkg;

    // Field widths (signed Q7.16 coordinates, unsigned Q7.16 extents).
    localparam int COORD_W   = 24;
    localparam int EXT_W     = 23;
    localparam int LOC_W     = 25;
    localparam int OFF_W     = 26;
    localparam int SQ_W      = 52;
    localparam int D2_W      = 40;
    localparam int ROOT_W    = 20;
    localparam int REM_W     = 22;
    localparam int DIST_W    = 21;
    localparam int DIV_W     = 22;
    localparam int Q_W       = 17;
    localparam int NORM_W    = 18;
    localparam int PUSH_W    = 31;
    localparam int LV_W      = 26;

    // Pipeline sizes.
    localparam int SQ_STAGES   = 20;
    localparam int DIV_STAGES  = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Fixed-point constants: 1.0, 0.0005 and 0.001 in Q.16.
    localparam logic signed [NORM_W-1:0] Q_ONE    = 18'sd65536;
    localparam logic [DIST_W-1:0]        DIST_EPS = 21'd33;
    localparam logic signed [63:0]       PUSH_EPS = 64'sd66;

    // Reset values of the configuration registers.
    localparam logic [EXT_W-1:0] RADIUS_RESET    = 23'd32768;
    localparam logic [EXT_W-1:0] RADIUS_SQ_RESET = 23'd16384;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_BALL_RADIUS    = 1'b0,
        REG_BALL_RADIUS_SQ = 1'b1
    } cfg_reg_t;

    // Region class of the circle center relative to the box.
    typedef enum logic [1:0] {
        KIND_CORNER = 2'd0,
        KIND_SIDE_X = 2'd1,
        KIND_SIDE_Y = 2'd2
    } kind_t;

    // One classified transaction as it travels from the front end to the back end.
    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [OFF_W-1:0]   dx;
        logic signed [OFF_W-1:0]   dy;
        kind_t                     kind;
        logic                      neg;
    } item_t;

    // Q.32 to Q.16, nearest, ties away from zero.
    function automatic logic signed [63:0] round_q16(input logic signed [63:0] v);
        logic signed [63:0] bias;
        bias = v[63] ? 64'sd32767 : 64'sd32768;
        return (v + bias) >>> 16;
    endfunction

    // Clamp to the 24-bit signed range.
    function automatic logic [COORD_W-1:0] sat24(input logic signed [63:0] v);
        logic [COORD_W-1:0] r;
        if (v > 64'sd8388607) begin
            r = 24'h7FFFFF;
        end else if (v < -64'sd8388608) begin
            r = 24'h800000;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: rtl/circle_box_collision_response_core.sv
// Throughput: one transaction per cycle; the square root and divider are fully pipelined,
// one result bit per stage, and the back end stalls as a whole only on m_ready.
// Reset (aresetn, synchronous, active low) empties all pipelines and the queue and
// loads ball_radius = 0.5 and ball_radius_squared = 0.25.
// Top level of the circle/box collision core; depends on cbc_pkg and all cbc_* modules.
`default_nettype none

module circle_box_collision_response_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [0:0]                          cfg_index,
    input  wire logic [cbc_pkg::EXT_W-1:0]           cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]  s_ball_x,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]  s_ball_y,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]  s_vel_x,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]  s_vel_y,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]  s_box_x,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]  s_box_y,
    input  wire logic [cbc_pkg::EXT_W-1:0]           s_half_width,
    input  wire logic [cbc_pkg::EXT_W-1:0]           s_half_height,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_hit,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_x,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_y,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_vel_x,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_vel_y
);

    logic [cbc_pkg::EXT_W-1:0] radius_reg, radius_sq_reg;
    logic                      q_full, q_empty, push, pop, en;
    cbc_pkg::item_t            push_item, head_item, norm_item;
    logic                      norm_valid, norm_far, norm_degen;
    logic [cbc_pkg::Q_W-1:0]   norm_qx, norm_qy;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg    <= cbc_pkg::RADIUS_RESET;
            radius_sq_reg <= cbc_pkg::RADIUS_SQ_RESET;
        end else if (cfg_wr_en) begin
            unique case (cbc_pkg::cfg_reg_t'(cfg_index))
                cbc_pkg::REG_BALL_RADIUS:    radius_reg    <= cfg_wdata;
                cbc_pkg::REG_BALL_RADIUS_SQ: radius_sq_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The back end draws from the queue whenever it advances.
    assign pop = en && !q_empty;

    cbc_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ball_x      (s_ball_x),
        .s_ball_y      (s_ball_y),
        .s_vel_x       (s_vel_x),
        .s_vel_y       (s_vel_y),
        .s_box_x       (s_box_x),
        .s_box_y       (s_box_y),
        .s_half_width  (s_half_width),
        .s_half_height (s_half_height),
        .q_full        (q_full),
        .push          (push),
        .push_item     (push_item)
    );

    cbc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_i    (push),
        .push_item (push_item),
        .pop_i     (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head_item (head_item)
    );

    cbc_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (!q_empty),
        .in_item   (head_item),
        .radius_sq (radius_sq_reg),
        .out_valid (norm_valid),
        .out_item  (norm_item),
        .out_far   (norm_far),
        .out_degen (norm_degen),
        .out_qx    (norm_qx),
        .out_qy    (norm_qy)
    );

    cbc_resp u_resp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (norm_valid),
        .in_item     (norm_item),
        .in_far      (norm_far),
        .in_degen    (norm_degen),
        .in_qx       (norm_qx),
        .in_qy       (norm_qy),
        .radius      (radius_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_new_x     (m_new_x),
        .m_new_y     (m_new_y),
        .m_new_vel_x (m_new_vel_x),
        .m_new_vel_y (m_new_vel_y)
    );

endmodule

`default_nettype wire

// File: rtl/cbc_front.sv
// Front end: takes input transactions, forms box-local offsets and sorts the
// center into corner or side classes, inside as a Y side. Depends on cbc_pkg.
`default_nettype none

module cbc_front (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]   s_ball_x,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]   s_ball_y,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]   s_vel_x,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]   s_vel_y,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]   s_box_x,
    input  wire logic signed [cbc_pkg::COORD_W-1:0]   s_box_y,
    input  wire logic [cbc_pkg::EXT_W-1:0]            s_half_width,
    input  wire logic [cbc_pkg::EXT_W-1:0]            s_half_height,
    input  wire logic                                 q_full,
    output logic                                      push,
    output cbc_pkg::item_t                            push_item
);

    logic                                  f1_vld_reg;
    logic signed [cbc_pkg::LOC_W-1:0]      lx_reg, ly_reg;
    logic [cbc_pkg::EXT_W-1:0]             hw_reg, hh_reg;
    logic signed [cbc_pkg::COORD_W-1:0]    bx_reg, by_reg, vx_reg, vy_reg;
    logic                                  f2_vld_reg;
    cbc_pkg::item_t                        item_reg;
    cbc_pkg::item_t                        item_next;
    logic                                  fen;
    logic signed [cbc_pkg::OFF_W-1:0]      lx_ext, ly_ext, hw_ext, hh_ext;
    logic                                  x_lo, x_hi, y_lo, y_hi;

    // The front stalls only when its last stage cannot hand over to the queue.
    assign fen     = !f2_vld_reg || !q_full;
    assign s_ready = fen;
    assign push    = f2_vld_reg && !q_full;
    assign push_item = item_reg;

    // Classification of the local offset against the box extents.
    always_comb begin
        lx_ext = cbc_pkg::OFF_W'(lx_reg);
        ly_ext = cbc_pkg::OFF_W'(ly_reg);
        hw_ext = signed'({3'b000, hw_reg});
        hh_ext = signed'({3'b000, hh_reg});
        x_lo = lx_ext < -hw_ext;
        x_hi = lx_ext > hw_ext;
        y_lo = ly_ext < -hh_ext;
        y_hi = ly_ext > hh_ext;

        item_next.bx = bx_reg;
        item_next.by = by_reg;
        item_next.vx = vx_reg;
        item_next.vy = vy_reg;
        item_next.dx = x_lo ? (lx_ext + hw_ext) : (lx_ext - hw_ext);
        item_next.dy = y_hi ? (ly_ext - hh_ext) : (ly_ext + hh_ext);
        if ((x_lo || x_hi) && (y_lo || y_hi)) begin
            item_next.kind = cbc_pkg::KIND_CORNER;
            item_next.neg  = 1'b0;
        end else if (x_lo || x_hi) begin
            item_next.kind = cbc_pkg::KIND_SIDE_X;
            item_next.neg  = x_lo;
        end else begin
            // A center inside the box is pushed along the lower face.
            item_next.kind = cbc_pkg::KIND_SIDE_Y;
            item_next.neg  = !y_hi;
        end
    end

    // Valid bits of the two front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else if (fen) begin
            f1_vld_reg <= s_valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    // Payload of the two front stages.
    always_ff @(posedge aclk) begin
        if (fen) begin
            lx_reg   <= cbc_pkg::LOC_W'(s_ball_x) - cbc_pkg::LOC_W'(s_box_x);
            ly_reg   <= cbc_pkg::LOC_W'(s_ball_y) - cbc_pkg::LOC_W'(s_box_y);
            hw_reg   <= s_half_width;
            hh_reg   <= s_half_height;
            bx_reg   <= s_ball_x;
            by_reg   <= s_ball_y;
            vx_reg   <= s_vel_x;
            vy_reg   <= s_vel_y;
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/cbc_queue.sv
// Short register queue that decouples the front end from the back end.
// Depends on cbc_pkg for the item type and depth.
`default_nettype none

module cbc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push_i,
    input  wire cbc_pkg::item_t  push_item,
    input  wire logic            pop_i,
    output logic                 full,
    output logic                 empty,
    output cbc_pkg::item_t       head_item
);

    logic [cbc_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [cbc_pkg::QUEUE_AW:0]   count_reg, count_next;
    cbc_pkg::item_t               mem_reg [cbc_pkg::QUEUE_DEPTH];
    logic                         do_push, do_pop;

    assign full      = count_reg == (cbc_pkg::QUEUE_AW + 1)'(cbc_pkg::QUEUE_DEPTH);
    assign empty     = count_reg == '0;
    assign do_push   = push_i && !full;
    assign do_pop    = pop_i && !empty;
    assign head_item = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (cbc_pkg::QUEUE_AW + 1)'(cbc_pkg::QUEUE_DEPTH))
        else $error("queue count exceeds depth");
    a_count_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow a push");
    a_count_down: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_pop && !do_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not follow a pop");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop_i && empty))
        else $error("pop requested from an empty queue");
`endif

endmodule

`default_nettype wire

// File: rtl/cbc_norm.sv
// Back end, first half: corner distance, pipelined square root and the two
// pipelined dividers that form the corner normal. Depends on cbc_pkg.
`default_nettype none

module cbc_norm (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire cbc_pkg::item_t                 in_item,
    input  wire logic [cbc_pkg::EXT_W-1:0]      radius_sq,
    output logic                                out_valid,
    output cbc_pkg::item_t                      out_item,
    output logic                                out_far,
    output logic                                out_degen,
    output logic [cbc_pkg::Q_W-1:0]             out_qx,
    output logic [cbc_pkg::Q_W-1:0]             out_qy
);

    localparam int NS = cbc_pkg::SQ_STAGES;
    localparam int ND = cbc_pkg::DIV_STAGES;

    // Squaring stage.
    logic                             s0_vld_reg;
    cbc_pkg::item_t                   s0_item_reg;
    logic [cbc_pkg::SQ_W-1:0]         sqx_reg, sqy_reg;

    // Square root stages.
    logic                             sq_vld_reg  [NS+1];
    cbc_pkg::item_t                   sq_item_reg [NS+1];
    logic                             sq_far_reg  [NS+1];
    logic [cbc_pkg::D2_W-1:0]         sq_n_reg    [NS+1];
    logic [cbc_pkg::REM_W-1:0]        sq_rem_reg  [NS+1];
    logic [cbc_pkg::ROOT_W-1:0]       sq_root_reg [NS+1];
    logic [cbc_pkg::D2_W-1:0]         sq_n_next    [NS];
    logic [cbc_pkg::REM_W-1:0]        sq_rem_next  [NS];
    logic [cbc_pkg::ROOT_W-1:0]       sq_root_next [NS];

    // Divider stages.
    logic                             dv_vld_reg   [ND+1];
    cbc_pkg::item_t                   dv_item_reg  [ND+1];
    logic                             dv_far_reg   [ND+1];
    logic                             dv_degen_reg [ND+1];
    logic [cbc_pkg::DIV_W-1:0]        dv_d_reg     [ND+1];
    logic [cbc_pkg::DIV_W-1:0]        dv_rx_reg    [ND+1];
    logic [cbc_pkg::DIV_W-1:0]        dv_ry_reg    [ND+1];
    logic [cbc_pkg::Q_W-1:0]          dv_qx_reg    [ND+1];
    logic [cbc_pkg::Q_W-1:0]          dv_qy_reg    [ND+1];
    logic [cbc_pkg::DIV_W-1:0]        dv_rx_next   [ND];
    logic [cbc_pkg::DIV_W-1:0]        dv_ry_next   [ND];
    logic [cbc_pkg::Q_W-1:0]          dv_qx_next   [ND];
    logic [cbc_pkg::Q_W-1:0]          dv_qy_next   [ND];

    logic [cbc_pkg::SQ_W:0]           d2_full;
    logic                             far_now;
    logic [cbc_pkg::DIST_W-1:0]       dist_rnd;
    logic [cbc_pkg::OFF_W-1:0]        absx, absy;
    logic [cbc_pkg::DIV_W-1:0]        rx_init, ry_init;

    // Squared distance and the comparison against the radius squared.
    always_comb begin
        d2_full = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        far_now = d2_full > {14'b0, radius_sq, 16'b0};
    end

    // One result bit of the square root per stage.
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            logic [cbc_pkg::REM_W+1:0] rs, t;
            rs = {sq_rem_reg[k], sq_n_reg[k][cbc_pkg::D2_W-1 -: 2]};
            t  = {2'b00, sq_root_reg[k], 2'b01};
            sq_n_next[k] = {sq_n_reg[k][cbc_pkg::D2_W-3:0], 2'b00};
            if (rs >= t) begin
                sq_rem_next[k]  = cbc_pkg::REM_W'(rs - t);
                sq_root_next[k] = {sq_root_reg[k][cbc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                sq_rem_next[k]  = rs[cbc_pkg::REM_W-1:0];
                sq_root_next[k] = {sq_root_reg[k][cbc_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    // Round the root to nearest and set up both divisions.
    always_comb begin
        dist_rnd = {1'b0, sq_root_reg[NS]}
                 + cbc_pkg::DIST_W'(sq_rem_reg[NS] > {2'b00, sq_root_reg[NS]});
        absx = sq_item_reg[NS].dx[cbc_pkg::OFF_W-1] ?
               unsigned'(-sq_item_reg[NS].dx) : unsigned'(sq_item_reg[NS].dx);
        absy = sq_item_reg[NS].dy[cbc_pkg::OFF_W-1] ?
               unsigned'(-sq_item_reg[NS].dy) : unsigned'(sq_item_reg[NS].dy);
        rx_init = {1'b0, absx[cbc_pkg::DIST_W-1:0]}
                + {18'b0, dist_rnd[cbc_pkg::DIST_W-1:17]};
        ry_init = {1'b0, absy[cbc_pkg::DIST_W-1:0]}
                + {18'b0, dist_rnd[cbc_pkg::DIST_W-1:17]};
    end

    // One quotient bit per stage; the low dividend bits are the divisor's own.
    always_comb begin
        for (int j = 0; j < ND; j++) begin
            logic [cbc_pkg::DIV_W:0] rsx, rsy, dd;
            dd  = {1'b0, dv_d_reg[j]};
            rsx = {dv_rx_reg[j], dv_d_reg[j][ND-j]};
            rsy = {dv_ry_reg[j], dv_d_reg[j][ND-j]};
            if (rsx >= dd) begin
                dv_rx_next[j] = cbc_pkg::DIV_W'(rsx - dd);
                dv_qx_next[j] = {dv_qx_reg[j][cbc_pkg::Q_W-2:0], 1'b1};
            end else begin
                dv_rx_next[j] = rsx[cbc_pkg::DIV_W-1:0];
                dv_qx_next[j] = {dv_qx_reg[j][cbc_pkg::Q_W-2:0], 1'b0};
            end
            if (rsy >= dd) begin
                dv_ry_next[j] = cbc_pkg::DIV_W'(rsy - dd);
                dv_qy_next[j] = {dv_qy_reg[j][cbc_pkg::Q_W-2:0], 1'b1};
            end else begin
                dv_ry_next[j] = rsy[cbc_pkg::DIV_W-1:0];
                dv_qy_next[j] = {dv_qy_reg[j][cbc_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    // Valid bits move in lockstep with the back end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
            for (int k = 0; k <= NS; k++) begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int j = 0; j <= ND; j++) begin
                dv_vld_reg[j] <= 1'b0;
            end
        end else if (en) begin
            s0_vld_reg    <= in_valid;
            sq_vld_reg[0] <= s0_vld_reg;
            for (int k = 0; k < NS; k++) begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
            dv_vld_reg[0] <= sq_vld_reg[NS];
            for (int j = 0; j < ND; j++) begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end
    end

    // Payload of all stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            s0_item_reg <= in_item;
            sqx_reg <= unsigned'(cbc_pkg::SQ_W'(in_item.dx) * cbc_pkg::SQ_W'(in_item.dx));
            sqy_reg <= unsigned'(cbc_pkg::SQ_W'(in_item.dy) * cbc_pkg::SQ_W'(in_item.dy));

            sq_item_reg[0] <= s0_item_reg;
            sq_far_reg[0]  <= far_now;
            sq_n_reg[0]    <= d2_full[cbc_pkg::D2_W-1:0];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < NS; k++) begin
                sq_item_reg[k+1] <= sq_item_reg[k];
                sq_far_reg[k+1]  <= sq_far_reg[k];
                sq_n_reg[k+1]    <= sq_n_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
            end

            dv_item_reg[0]  <= sq_item_reg[NS];
            dv_far_reg[0]   <= sq_far_reg[NS];
            dv_degen_reg[0] <= dist_rnd < cbc_pkg::DIST_EPS;
            dv_d_reg[0]     <= {dist_rnd, 1'b0};
            dv_rx_reg[0]    <= rx_init;
            dv_ry_reg[0]    <= ry_init;
            dv_qx_reg[0]    <= '0;
            dv_qy_reg[0]    <= '0;
            for (int j = 0; j < ND; j++) begin
                dv_item_reg[j+1]  <= dv_item_reg[j];
                dv_far_reg[j+1]   <= dv_far_reg[j];
                dv_degen_reg[j+1] <= dv_degen_reg[j];
                dv_d_reg[j+1]     <= dv_d_reg[j];
                dv_rx_reg[j+1]    <= dv_rx_next[j];
                dv_ry_reg[j+1]    <= dv_ry_next[j];
                dv_qx_reg[j+1]    <= dv_qx_next[j];
                dv_qy_reg[j+1]    <= dv_qy_next[j];
            end
        end
    end

    assign out_valid = dv_vld_reg[ND];
    assign out_item  = dv_item_reg[ND];
    assign out_far   = dv_far_reg[ND];
    assign out_degen = dv_degen_reg[ND];
    assign out_qx    = dv_qx_reg[ND];
    assign out_qy    = dv_qy_reg[ND];

endmodule

`default_nettype wire

// File: rtl/cbc_resp.sv
// Back end, second half: push-out depth, position correction, velocity
// reflection, saturation and the output register. Depends on cbc_pkg.
`default_nettype none

module cbc_resp (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    output logic                                     en,
    input  wire logic                                in_valid,
    input  wire cbc_pkg::item_t                      in_item,
    input  wire logic                                in_far,
    input  wire logic                                in_degen,
    input  wire logic [cbc_pkg::Q_W-1:0]             in_qx,
    input  wire logic [cbc_pkg::Q_W-1:0]             in_qy,
    input  wire logic [cbc_pkg::EXT_W-1:0]           radius,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_hit,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_x,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_y,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_vel_x,
    output logic signed [cbc_pkg::COORD_W-1:0]       m_new_vel_y
);

    logic                                r_vld_reg  [4];
    cbc_pkg::item_t                      r_item_reg [4];
    logic                                r_hit_reg  [4];
    logic signed [cbc_pkg::NORM_W-1:0]   r_nx_reg   [4];
    logic signed [cbc_pkg::NORM_W-1:0]   r_ny_reg   [4];

    logic signed [43:0]                  pdx_reg, pdy_reg;
    logic signed [41:0]                  pvx_reg, pvy_reg;
    logic signed [44:0]                  dot_reg;
    logic signed [42:0]                  vdot_reg;
    logic signed [cbc_pkg::PUSH_W-1:0]   push_reg;
    logic signed [cbc_pkg::LV_W-1:0]     lv_reg;
    logic signed [48:0]                  mx_reg, my_reg;
    logic signed [43:0]                  wx_reg, wy_reg;

    logic                                out_vld_reg, out_hit_reg;
    logic [cbc_pkg::COORD_W-1:0]         out_x_reg, out_y_reg, out_vx_reg, out_vy_reg;

    logic signed [cbc_pkg::NORM_W-1:0]   nx, ny;
    logic                                hit_now;
    logic signed [63:0]                  dot_r, push64, lv64;
    logic signed [63:0]                  x64, y64, vx64, vy64;

    // The whole back end advances when the output register is free.
    assign en = !out_vld_reg || m_ready;

    // Normal selection and the hit decision.
    always_comb begin
        nx = '0;
        ny = '0;
        hit_now = 1'b1;
        case (in_item.kind)
            cbc_pkg::KIND_CORNER: begin
                nx = in_item.dx[cbc_pkg::OFF_W-1] ? -signed'({1'b0, in_qx})
                                                  : signed'({1'b0, in_qx});
                ny = in_item.dy[cbc_pkg::OFF_W-1] ? -signed'({1'b0, in_qy})
                                                  : signed'({1'b0, in_qy});
                hit_now = !in_far && !in_degen;
            end
            cbc_pkg::KIND_SIDE_X: begin
                nx = in_item.neg ? -cbc_pkg::Q_ONE : cbc_pkg::Q_ONE;
            end
            default: begin
                ny = in_item.neg ? -cbc_pkg::Q_ONE : cbc_pkg::Q_ONE;
            end
        endcase
    end

    // Penetration depth with the push margin, and the approaching speed.
    always_comb begin
        dot_r  = cbc_pkg::round_q16(64'(dot_reg));
        push64 = signed'({41'b0, radius}) + cbc_pkg::PUSH_EPS - dot_r;
        lv64   = -cbc_pkg::round_q16(64'(vdot_reg));
    end

    // Final corrections with saturation.
    always_comb begin
        x64  = 64'(r_item_reg[3].bx) + cbc_pkg::round_q16(64'(mx_reg));
        y64  = 64'(r_item_reg[3].by) + cbc_pkg::round_q16(64'(my_reg));
        vx64 = 64'(r_item_reg[3].vx) + cbc_pkg::round_q16(64'(wx_reg) <<< 1);
        vy64 = 64'(r_item_reg[3].vy) + cbc_pkg::round_q16(64'(wy_reg) <<< 1);
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                r_vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end else if (en) begin
            r_vld_reg[0] <= in_valid;
            for (int i = 0; i < 3; i++) begin
                r_vld_reg[i+1] <= r_vld_reg[i];
            end
            out_vld_reg <= r_vld_reg[3];
        end
    end

    // Payload stages: products, sums, depth, scaled normals, output.
    always_ff @(posedge aclk) begin
        if (en) begin
            r_item_reg[0] <= in_item;
            r_hit_reg[0]  <= hit_now;
            r_nx_reg[0]   <= nx;
            r_ny_reg[0]   <= ny;
            for (int i = 0; i < 3; i++) begin
                r_item_reg[i+1] <= r_item_reg[i];
                r_hit_reg[i+1]  <= r_hit_reg[i];
                r_nx_reg[i+1]   <= r_nx_reg[i];
                r_ny_reg[i+1]   <= r_ny_reg[i];
            end

            pdx_reg <= 44'(in_item.dx) * 44'(nx);
            pdy_reg <= 44'(in_item.dy) * 44'(ny);
            pvx_reg <= 42'(in_item.vx) * 42'(nx);
            pvy_reg <= 42'(in_item.vy) * 42'(ny);

            dot_reg  <= 45'(pdx_reg) + 45'(pdy_reg);
            vdot_reg <= 43'(pvx_reg) + 43'(pvy_reg);

            push_reg <= push64[cbc_pkg::PUSH_W-1:0];
            lv_reg   <= lv64[63] ? '0 : lv64[cbc_pkg::LV_W-1:0];

            mx_reg <= 49'(r_nx_reg[2]) * 49'(push_reg);
            my_reg <= 49'(r_ny_reg[2]) * 49'(push_reg);
            wx_reg <= 44'(r_nx_reg[2]) * 44'(lv_reg);
            wy_reg <= 44'(r_ny_reg[2]) * 44'(lv_reg);

            out_hit_reg <= r_hit_reg[3];
            if (r_hit_reg[3]) begin
                out_x_reg  <= cbc_pkg::sat24(x64);
                out_y_reg  <= cbc_pkg::sat24(y64);
                out_vx_reg <= cbc_pkg::sat24(vx64);
                out_vy_reg <= cbc_pkg::sat24(vy64);
            end else begin
                out_x_reg  <= r_item_reg[3].bx;
                out_y_reg  <= r_item_reg[3].by;
                out_vx_reg <= r_item_reg[3].vx;
                out_vy_reg <= r_item_reg[3].vy;
            end
        end
    end

    assign m_valid     = out_vld_reg;
    assign m_hit       = out_hit_reg;
    assign m_new_x     = signed'(out_x_reg);
    assign m_new_y     = signed'(out_y_reg);
    assign m_new_vel_x = signed'(out_vx_reg);
    assign m_new_vel_y = signed'(out_vy_reg);

endmodule

`default_nettype wire
